[design/hslp_pkg.sv]
// Package for the hashed slot map: opcodes, status codes, table entry type
// and hash constants. Used by every module of the block.
package hslp_pkg;

  localparam int unsigned SLOTS_DEF     = 1024;
  localparam int unsigned HANDLE_BITS   = 16;
  localparam int unsigned KEY_WORDS_MAX = 2;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP   = 2'd2;
  localparam logic [1:0] OP_CONTAINS = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd4;

  localparam logic [1:0] CFG_KEY_WORDS  = 2'd0;
  localparam logic [1:0] CFG_TOMBSTONE  = 2'd1;
  localparam logic [1:0] CFG_SUBSTITUTE = 2'd2;

  typedef struct packed {
    logic [31:0]            tag;
    logic [HANDLE_BITS-1:0] handle;
    logic [63:0]            key;
  } entry_t;

endpackage

[design/hslp_if.sv]
// Valid/ready channels of the hashed slot map: request and result words.
// Depends on nothing.
interface hslp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key;
  logic [15:0] handle;
  logic [9:0]  slot;
  modport source (output valid, opcode, key, handle, slot, input ready);
  modport sink   (input valid, opcode, key, handle, slot, output ready);
endinterface

interface hslp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot_out;
  logic [15:0] handle_out;
  logic        found;
  modport source (output valid, status, slot_out, handle_out, found, input ready);
  modport sink   (input valid, status, slot_out, handle_out, found, output ready);
endinterface

[design/hslp_hash.sv]
// Iterative FNV-1a hash, one key byte per cycle, with substitute code.
// Depends on hslp_pkg.
module hslp_hash import hslp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        two_words_i,
  input  logic [63:0] key_i,
  input  logic [31:0] tomb_i,
  input  logic [31:0] subst_i,
  output logic        done_o,
  output logic [31:0] hash_o
);

  logic        busy_q;
  logic        done_q;
  logic [2:0]  idx_q;
  logic [2:0]  last_q;
  logic [31:0] h_q;
  logic [7:0]  byte_sel;

  assign byte_sel = key_i[{idx_q, 3'b000} +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      last_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        last_q <= two_words_i ? 3'd7 : 3'd3;
      end else if (busy_q) begin
        if (idx_q == last_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q <= FNV_BASIS;
    end else if (busy_q) begin
      h_q <= (h_q ^ {24'd0, byte_sel}) * FNV_PRIME;
    end
  end

  assign done_o = done_q;
  assign hash_o = (h_q == 32'd0 || h_q == tomb_i) ? subst_i : h_q;

endmodule

[design/hslp_table.sv]
// Slot table memory: one entry per slot, registered read, clearing sweep
// after reset. Depends on hslp_pkg.
module hslp_table import hslp_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned SW = $clog2(SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [SW-1:0] rd_addr_i,
  output entry_t        rd_data_o,
  input  logic          we_i,
  input  logic [SW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  output logic          ready_o
);

  entry_t        mem [SLOTS];
  logic          clearing_q;
  logic [SW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == SW'(SLOTS - 1)) clearing_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_q] <= '0;
    end else if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  assign ready_o = !clearing_q;

endmodule

[design/hashed_slot_map_linear_probe.sv]
// Hashed slot map with linear probing: open-addressing table of handles.
// Depends on hslp_pkg, hslp_if, hslp_hash and hslp_table.
//
// Channels: in_i takes request words (opcode, key, handle, slot), out_o
// gives one result word per request. Both are valid/ready; a word moves on
// a clock edge with valid and ready high. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Flow: remove and contains read and check the slot named in the request,
// or report bad slot if it is out of range. Add and lookup first hash the
// 4 or 8 key bytes one byte a cycle, then probe one slot a cycle through
// the table memory's read port. One request is in work at a time; a new
// one is taken as soon as the previous result sits in the output register,
// even if the receiver has not taken it yet.
// Reset: the tag store is swept to empty, one slot a cycle; no request is
// taken meanwhile. Configuration writes are taken as ever.
// Stall: a held result blocks the next one; the block waits at completion.
module hashed_slot_map_linear_probe import hslp_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  hslp_in_if.sink     in_i,
  hslp_out_if.source  out_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned FW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [1:0]  key_words_q;
  logic [31:0] tomb_q;
  logic [31:0] subst_q;

  logic [2:0]             state_q, state_d;
  logic [1:0]             op_q;
  logic [63:0]            key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [31:0]            h_q, h_d;
  logic [SW-1:0]          pos_q, pos_d;
  logic [SW-1:0]          cnt_q, cnt_d;
  logic [FW-1:0]          free_q, free_d;

  logic [2:0]             res_status_q, res_status_d;
  logic [9:0]             res_slot_q, res_slot_d;
  logic [15:0]            res_handle_q, res_handle_d;
  logic                   res_found_q, res_found_d;

  logic                   out_valid_q;
  logic [2:0]             out_status_q;
  logic [9:0]             out_slot_q;
  logic [15:0]            out_handle_q;
  logic                   out_found_q;

  logic          accept;
  logic          hash_start;
  logic          hash_done;
  logic [31:0]   hash_val;
  logic          tbl_ready;
  logic [SW-1:0] rd_addr;
  entry_t        rd_data;
  logic          we;
  entry_t        wr_data;
  logic          slot_ok;
  logic          tag_free;
  logic          tag_live;
  logic [63:0]   key_mask;
  logic          out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_words_q <= 2'd1;
      tomb_q      <= 32'd1;
      subst_q     <= 32'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_WORDS:  key_words_q <= cfg_data_i[1:0];
        CFG_TOMBSTONE:  tomb_q      <= cfg_data_i;
        CFG_SUBSTITUTE: subst_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign slot_ok    = (17'(in_i.slot) < 17'(SLOTS));
  assign hash_start = accept && (in_i.opcode == OP_ADD || in_i.opcode == OP_LOOKUP);
  assign out_free   = !out_valid_q || out_o.ready;

  // Key words above one only when the register asks for two or more.
  assign key_mask = key_words_q[1] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
  assign tag_free = (rd_data.tag == 32'd0) || (rd_data.tag == tomb_q);
  assign tag_live = !tag_free;

  hslp_hash u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (hash_start),
    .two_words_i (key_words_q[1]),
    .key_i       (key_q),
    .tomb_i      (tomb_q),
    .subst_i     (subst_q),
    .done_o      (hash_done),
    .hash_o      (hash_val)
  );

  hslp_table #(.SLOTS(SLOTS)) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .we_i      (we),
    .wr_addr_i (pos_q),
    .wr_data_i (wr_data),
    .ready_o   (tbl_ready)
  );

  always_comb begin
    state_d      = state_q;
    h_d          = h_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_handle_d = res_handle_q;
    res_found_d  = res_found_q;
    rd_addr      = pos_q;
    we           = 1'b0;
    wr_data      = '{tag: h_q, handle: handle_q, key: key_q};

    case (state_q)
      S_CLEAR: begin
        if (tbl_ready) state_d = S_IDLE;
      end
      S_IDLE: begin
        res_status_d = ST_NOT_FOUND;
        res_slot_d   = '0;
        res_handle_d = '0;
        res_found_d  = 1'b0;
        rd_addr      = SW'(in_i.slot);
        pos_d        = SW'(in_i.slot);
        cnt_d        = '0;
        if (accept) begin
          if (hash_start) begin
            state_d = S_HASH;
          end else if (slot_ok) begin
            state_d = S_CHECK;
          end else begin
            res_status_d = ST_BAD_SLOT;
            state_d      = S_DONE;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          h_d     = hash_val;
          pos_d   = hash_val[SW-1:0];
          rd_addr = hash_val[SW-1:0];
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_DONE;
        case (op_q)
          OP_ADD: begin
            if (tag_free) begin
              we           = 1'b1;
              res_status_d = ST_OK;
              res_slot_d   = 10'(pos_q);
              if (free_q != '0) free_d = free_q - 1'b1;
            end else if (rd_data.tag == h_q && rd_data.handle == handle_q) begin
              res_status_d = ST_DUP;
            end else if (cnt_q == SW'(SLOTS - 1)) begin
              res_status_d = ST_FULL;
            end else begin
              // advance to the next slot; next read issued now
              state_d = S_CHECK;
              pos_d   = pos_q + 1'b1;
              cnt_d   = cnt_q + 1'b1;
              rd_addr = pos_q + 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (rd_data.tag == 32'd0) begin
              res_status_d = ST_NOT_FOUND;
            end else if (rd_data.tag == h_q && ((rd_data.key ^ key_q) & key_mask) == 64'd0) begin
              res_status_d = ST_OK;
              res_found_d  = 1'b1;
              res_slot_d   = 10'(pos_q);
              res_handle_d = 16'(rd_data.handle);
            end else if (cnt_q == SW'(SLOTS - 1)) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              state_d = S_CHECK;
              pos_d   = pos_q + 1'b1;
              cnt_d   = cnt_q + 1'b1;
              rd_addr = pos_q + 1'b1;
            end
          end
          OP_REMOVE: begin
            if (tag_live && rd_data.handle == handle_q) begin
              we           = 1'b1;
              wr_data      = '{tag: tomb_q, handle: rd_data.handle, key: rd_data.key};
              res_status_d = ST_OK;
              if (free_q != FW'(SLOTS)) free_d = free_q + 1'b1;
            end else begin
              res_status_d = ST_BAD_SLOT;
            end
          end
          default: begin
            if (tag_live && rd_data.handle == handle_q) begin
              res_status_d = ST_OK;
              res_found_d  = 1'b1;
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end
        endcase
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      free_q      <= FW'(SLOTS);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_i.opcode;
      key_q    <= in_i.key;
      handle_q <= HANDLE_BITS'(in_i.handle);
    end
    h_q          <= h_d;
    pos_q        <= pos_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_handle_q <= res_handle_d;
    res_found_q  <= res_found_d;
    // load the result word once the output register is free
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_handle_q <= res_handle_q;
      out_found_q  <= res_found_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot_out   = out_slot_q;
  assign out_o.handle_out = out_handle_q;
  assign out_o.found      = out_found_q;

endmodule

[tb/tb_top.sv]
// Self-checking bench for hashed_slot_map_linear_probe: drives requests,
// predicts each result from a table model of its own and checks it.
// Depends on hslp_pkg, hslp_if and the block's RTL.
module tb_top;
  import hslp_pkg::*;

  localparam int unsigned NSLOT = SLOTS_DEF;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [15:0] handle;
    logic [9:0]  slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [15:0] handle;
    logic        found;
  } res_t;

  typedef struct packed {
    logic [9:0]  slot;
    logic [15:0] handle;
    logic [63:0] key;
  } entry_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  hslp_in_if  in_if ();
  hslp_out_if out_if ();

  hashed_slot_map_linear_probe u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk_i = ~clk_i;

  // table model state
  logic [31:0] mdl_tag [NSLOT];
  logic [15:0] mdl_hnd [NSLOT];
  logic [63:0] mdl_key [NSLOT];
  int unsigned mdl_free;
  logic [1:0]  mdl_words;
  logic [31:0] mdl_tomb;
  logic [31:0] mdl_subst;

  res_t        due_results [$];
  entry_rec_t  live_entries [$];
  logic [63:0] key_pool [16];
  int unsigned errors;
  int unsigned req_count;
  int unsigned status_seen [5];
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned stall_cnt;

  function automatic int unsigned word_count();
    if (mdl_words == 2'd0) return 1;
    if (mdl_words > KEY_WORDS_MAX) return KEY_WORDS_MAX;
    return mdl_words;
  endfunction

  function automatic logic [31:0] fnv_raw(logic [63:0] key, int unsigned nw);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int b = 0; b < 4 * nw; b++) begin
      h = h ^ {24'd0, key[8*b +: 8]};
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  function automatic logic [31:0] key_hash(logic [63:0] key);
    logic [31:0] h;
    h = fnv_raw(key, word_count());
    if (h == 32'd0 || h == mdl_tomb) h = mdl_subst;
    return h;
  endfunction

  function automatic bit slot_live(logic [9:0] s);
    return mdl_tag[s] != 32'd0 && mdl_tag[s] != mdl_tomb;
  endfunction

  // Apply one request to the model and give the result it must produce.
  function automatic res_t table_response(req_t r);
    res_t        res;
    logic [31:0] h;
    logic [9:0]  pos;
    logic [63:0] m;
    res = '0;
    res.status = ST_NOT_FOUND;
    case (r.op)
      OP_ADD: begin
        h = key_hash(r.key);
        pos = h[9:0];
        res.status = ST_FULL;
        for (int n = 0; n < NSLOT; n++) begin
          if (mdl_tag[pos] == 32'd0 || mdl_tag[pos] == mdl_tomb) begin
            mdl_tag[pos] = h;
            mdl_hnd[pos] = r.handle;
            mdl_key[pos] = r.key;
            if (mdl_free > 0) mdl_free--;
            res.status = ST_OK;
            res.slot = pos;
            break;
          end
          if (mdl_tag[pos] == h && mdl_hnd[pos] == r.handle) begin
            res.status = ST_DUP;
            break;
          end
          pos = pos + 10'd1;
        end
      end
      OP_REMOVE: begin
        if (slot_live(r.slot) && mdl_hnd[r.slot] == r.handle) begin
          mdl_tag[r.slot] = mdl_tomb;
          if (mdl_free < NSLOT) mdl_free++;
          res.status = ST_OK;
        end else begin
          res.status = ST_BAD_SLOT;
        end
      end
      OP_LOOKUP: begin
        m = (word_count() >= 2) ? '1 : 64'h0000_0000_FFFF_FFFF;
        h = key_hash(r.key);
        pos = h[9:0];
        for (int n = 0; n < NSLOT; n++) begin
          if (mdl_tag[pos] == 32'd0) break;
          if (mdl_tag[pos] == h && ((mdl_key[pos] ^ r.key) & m) == 64'd0) begin
            res.status = ST_OK;
            res.found = 1'b1;
            res.slot = pos;
            res.handle = mdl_hnd[pos];
            break;
          end
          pos = pos + 10'd1;
        end
      end
      default: begin
        if (slot_live(r.slot) && mdl_hnd[r.slot] == r.handle) begin
          res.status = ST_OK;
          res.found = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h (result %0d)", what, got, want, req_count);
    errors++;
  endtask

  // Offer one word; returns once the block has taken it.
  task automatic send_req(req_t r, output res_t res);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    res = table_response(r);
    if (r.op == OP_ADD && res.status == ST_OK)
      live_entries.push_back('{slot: res.slot, handle: r.handle, key: r.key});
    in_if.valid  <= 1'b1;
    in_if.opcode <= r.op;
    in_if.key    <= r.key;
    in_if.handle <= r.handle;
    in_if.slot   <= r.slot;
    do @(posedge clk_i); while (!in_if.ready);
    due_results.push_back(res);
  endtask

  task automatic send_op(logic [1:0] op, logic [63:0] key, logic [15:0] hnd,
                         logic [9:0] slot);
    res_t res;
    send_req('{op: op, key: key, handle: hnd, slot: slot}, res);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_KEY_WORDS: mdl_words = val[1:0];
      CFG_TOMBSTONE: mdl_tomb = val;
      default:       mdl_subst = val;
    endcase
  endtask

  task automatic rand_req(output req_t r);
    int unsigned sel;
    int unsigned i;
    entry_rec_t  e;
    sel = $urandom_range(99);
    r.key = ($urandom_range(1) != 0) ? key_pool[$urandom_range(15)]
                                     : {$urandom, $urandom};
    r.handle = ($urandom_range(1) != 0) ? 16'($urandom_range(7)) : 16'($urandom);
    r.slot = 10'($urandom);
    if (sel < 40) begin
      r.op = OP_ADD;
    end else if (sel < 60) begin
      r.op = OP_REMOVE;
      if (live_entries.size() != 0 && $urandom_range(99) < 80) begin
        i = $urandom_range(live_entries.size() - 1);
        e = live_entries[i];
        live_entries.delete(i);
        r.slot = e.slot;
        r.handle = e.handle;
      end
    end else if (sel < 80) begin
      r.op = OP_LOOKUP;
      if (live_entries.size() != 0 && $urandom_range(1) != 0)
        r.key = live_entries[$urandom_range(live_entries.size() - 1)].key;
    end else begin
      r.op = OP_CONTAINS;
      if (live_entries.size() != 0 && $urandom_range(99) < 60) begin
        e = live_entries[$urandom_range(live_entries.size() - 1)];
        r.slot = e.slot;
        r.handle = ($urandom_range(3) == 0) ? ~e.handle : e.handle;
      end
    end
  endtask

  task automatic test_basic();
    res_t res;
    send_req('{op: OP_ADD, key: 64'd0, handle: 16'h0000, slot: 10'd0}, res);
    send_op(OP_ADD, '1, 16'hFFFF, 10'h3FF);
    send_req('{op: OP_ADD, key: 64'h1234, handle: 16'h00A5, slot: 10'd0}, res);
    send_op(OP_ADD, 64'h1234, 16'h00A5, 10'd0);   // duplicate
    send_op(OP_ADD, 64'h1234, 16'h005A, 10'd0);   // same key, new handle
    send_op(OP_LOOKUP, 64'h1234, 16'd0, 10'd0);
    send_op(OP_LOOKUP, 64'hDEAD_0000_BEEF, 16'd0, 10'd0);
    send_op(OP_CONTAINS, 64'd0, 16'h00A5, res.slot);
    send_op(OP_CONTAINS, 64'd0, 16'h005A, res.slot);
    send_op(OP_CONTAINS, 64'd0, 16'h00A5, res.slot + 10'd7);
    send_op(OP_REMOVE, 64'd0, 16'h005A, res.slot);
    send_op(OP_REMOVE, 64'd0, 16'h00A5, res.slot);
    send_op(OP_REMOVE, 64'd0, 16'h00A5, res.slot);  // already removed
    send_op(OP_CONTAINS, 64'd0, 16'h00A5, res.slot);
    send_op(OP_LOOKUP, 64'h1234, 16'd0, 10'd0);      // probe over tombstone
  endtask

  task automatic test_odd_codes();
    logic [63:0] k;
    k = 64'hCAFE_0000_0000_0042;
    write_reg(CFG_KEY_WORDS, 32'd1);
    // hash of k equals the tombstone: substitute code takes its place
    write_reg(CFG_TOMBSTONE, fnv_raw(k, 1));
    send_op(OP_ADD, k, 16'h0101, 10'd0);
    send_op(OP_LOOKUP, k, 16'd0, 10'd0);
    write_reg(CFG_SUBSTITUTE, mdl_tomb);   // stored tag reads as removed
    send_op(OP_ADD, k, 16'h0202, 10'd0);
    send_op(OP_LOOKUP, k, 16'd0, 10'd0);
    write_reg(CFG_SUBSTITUTE, 32'd0);      // stored tag reads as empty
    send_op(OP_ADD, k, 16'h0303, 10'd0);
    send_op(OP_LOOKUP, k, 16'd0, 10'd0);
    write_reg(CFG_TOMBSTONE, 32'hFFFF_FFFF);
    write_reg(CFG_SUBSTITUTE, 32'hFFFF_FFFF);
  endtask

  task automatic test_key_words();
    write_reg(CFG_KEY_WORDS, 32'd0);
    send_op(OP_ADD, 64'h5555_0000_0000_0777, 16'h0011, 10'd0);
    send_op(OP_LOOKUP, 64'h0000_0000_0000_0777, 16'd0, 10'd0);
    write_reg(CFG_KEY_WORDS, 32'd3);
    send_op(OP_ADD, 64'h5555_0000_0000_0777, 16'h0022, 10'd0);
    send_op(OP_LOOKUP, 64'h0000_0000_0000_0777, 16'd0, 10'd0);
    send_op(OP_LOOKUP, 64'h5555_0000_0000_0777, 16'd0, 10'd0);
  endtask

  task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    req_t r;
    res_t res;
    snd_idle_pct = s_pct;
    rcv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      rand_req(r);
      send_req(r, res);
    end
  endtask

  task automatic test_pressure();
    req_t r;
    res_t res;
    snd_idle_pct = 0;
    hold_req = 300;
    for (int i = 0; i < 20; i++) begin
      rand_req(r);
      send_req(r, res);
    end
    // pause until the block has handed back everything
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 10; i++) begin
      rand_req(r);
      send_req(r, res);
    end
  endtask

  // result receiver: random stalls plus requested long hold-offs
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // result checker and stall watchdog
  always @(posedge clk_i) begin
    res_t want;
    if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (out_if.valid && out_if.ready) begin
      req_count++;
      if (due_results.size() == 0) begin
        report("unexpected result word", 32'd1, 32'd0);
      end else begin
        want = due_results.pop_front();
        if (out_if.status <= ST_BAD_SLOT) status_seen[out_if.status]++;
        if (out_if.status !== want.status) report("status", out_if.status, want.status);
        if (out_if.slot_out !== want.slot) report("slot_out", out_if.slot_out, want.slot);
        if (out_if.handle_out !== want.handle)
          report("handle_out", out_if.handle_out, want.handle);
        if (out_if.found !== want.found) report("found", out_if.found, want.found);
      end
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) mdl_tag[i] = 32'd0;
    mdl_free = NSLOT;
    mdl_words = 2'd1;
    mdl_tomb = 32'd1;
    mdl_subst = 32'd2;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    errors = 0;
    req_count = 0;
    stall_cnt = 0;
    hold_req = 0;
    hold_left = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_KEY_WORDS;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.opcode <= OP_ADD;
    in_if.key <= '0;
    in_if.handle <= '0;
    in_if.slot <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic();
    test_key_words();
    test_odd_codes();
    write_reg(CFG_KEY_WORDS, 32'd1);
    test_random(300, 34, 87);
    write_reg(CFG_KEY_WORDS, 32'd2);
    write_reg(CFG_TOMBSTONE, 32'h8000_0000);
    test_random(300, 87, 34);
    test_pressure();
    write_reg(CFG_KEY_WORDS, 32'd1);
    write_reg(CFG_SUBSTITUTE, 32'h0000_03FF);
    test_random(300, 0, 0);

    drain();
    repeat (50) @(posedge clk_i);
    $display("Checked %0d results over add, remove, lookup and contains, with", req_count);
    $display("  ok %0d, not found %0d, duplicate %0d, full %0d, bad slot %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (errors == 0 && due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
design/hslp_pkg.sv
design/hslp_if.sv
design/hslp_hash.sv
design/hslp_table.sv
design/hashed_slot_map_linear_probe.sv
tb/tb_top.sv
